// ===== design/lfta_pkg.sv =====
package lfta_pkg;

  localparam int unsigned MaxTagsDefault   = 65536;
  localparam int unsigned StartSizeDefault = 1024;
  localparam int unsigned TagW             = 16;
  localparam int unsigned SizeW            = 17;
  localparam int unsigned WordW            = 64;
  localparam int unsigned BitIdxW          = 6;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  // Lowest set bit of a word; 63 when the word is zero.
  function automatic logic [BitIdxW-1:0] low_bit(input logic [WordW-1:0] v);
    logic [BitIdxW-1:0] n;
    n = BitIdxW'(WordW - 1);
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = BitIdxW'(i);
      end
    end
    return n;
  endfunction

endpackage

// ===== design/lfta_sum_mem.sv =====
module lfta_sum_mem #(
  parameter int unsigned SumWords = 16,
  parameter int unsigned AddrW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AddrW-1:0]           waddr,
  input  logic [lfta_pkg::WordW-1:0] wdata,
  input  logic [AddrW-1:0]           raddr,
  output logic [lfta_pkg::WordW-1:0] rdata
);

  logic [lfta_pkg::WordW-1:0] mem [SumWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lfta_map_mem.sv =====
module lfta_map_mem #(
  parameter int unsigned MapWords = 1024,
  parameter int unsigned AddrW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AddrW-1:0]           waddr,
  input  logic [lfta_pkg::WordW-1:0] wdata,
  input  logic [AddrW-1:0]           raddr,
  output logic [lfta_pkg::WordW-1:0] rdata
);

  logic [lfta_pkg::WordW-1:0] mem [MapWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lowest_free_tag_allocator.sv =====
// Lowest-free tag allocator.
// Input channel (in_valid/in_ready, kind, tag): kind 0 asks for a tag, kind 1
// hands tag back. Output channel (out_valid/out_ready): granted_tag, ok, grew,
// pool_size and available, one result per request.
// Tag 0 is reserved. An allocate takes the lowest free tag below the pool
// size; when none is free the pool doubles (up to MAX_TAGS) and the old size
// is granted with grew set. The free bitmap sits in a 64-bit-wide memory, and
// a summary memory holds one bit per bitmap word that still has a free tag.
// Steps: an allocate reads summary words in order until one has a free bit,
// reads that bitmap word, then writes both back; each empty summary word
// skipped adds another summary read. A free reads its bitmap word and
// summary word and writes back. The next request is taken the cycle after
// the write-back; a new request is not taken while another is in flight.
// After reset a clearing pass writes every bitmap and summary word, one word
// per cycle; in_ready stays low during it.
// When the receiver stalls, hold the result in the output register; the next
// request still transfers and advances up to the write-back, where it waits
// until the held result has transferred.
module lowest_free_tag_allocator #(
  parameter int unsigned MAX_TAGS   = lfta_pkg::MaxTagsDefault,
  parameter int unsigned START_SIZE = lfta_pkg::StartSizeDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [lfta_pkg::TagW-1:0]     tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfta_pkg::TagW-1:0]     granted_tag,
  output logic                          ok,
  output logic                          grew,
  output logic [lfta_pkg::SizeW-1:0]    pool_size,
  output logic [lfta_pkg::TagW-1:0]     available
);

  localparam int unsigned MapWords = (MAX_TAGS + 63) / 64;
  localparam int unsigned SumWords = (MapWords + 63) / 64;
  localparam int unsigned MapAW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned SumAW    = (SumWords > 1) ? $clog2(SumWords) : 1;
  localparam int unsigned SzW      = $clog2(MAX_TAGS) + 1;
  localparam int unsigned CntW     = $clog2(MAX_TAGS);
  localparam int unsigned TW       = lfta_pkg::TagW;
  localparam int unsigned WW       = lfta_pkg::WordW;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SREAD = 7'b0000100,
    ST_SEL   = 7'b0001000,
    ST_MREAD = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state;
  logic [MapAW:0]    clr_cnt;
  logic              req_kind;
  logic [TW-1:0]     req_tag;
  logic [SzW-1:0]    active_size;
  logic [CntW-1:0]   avail_cnt;
  logic [SumAW-1:0]  scan_idx;
  logic              found;
  logic [MapAW-1:0]  word_idx;

  logic              sum_we, map_we;
  logic [SumAW-1:0]  sum_waddr, sum_raddr;
  logic [MapAW-1:0]  map_waddr, map_raddr;
  logic [WW-1:0]     sum_wdata, map_wdata, sum_rdata, map_rdata;

  lfta_sum_mem #(.SumWords(SumWords), .AddrW(SumAW)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  lfta_map_mem #(.MapWords(MapWords), .AddrW(MapAW)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // Target word for a free request, and the word of the granted tag.
  logic [MapAW-1:0]  free_word;
  logic [SzW-1:0]    free_tag_ext;
  logic              free_legal;
  logic [SzW-1:0]    grant_tag;
  logic [MapAW-1:0]  grant_word;
  logic              grant_ok, grant_grew;
  logic [SzW-1:0]    map_hit;
  logic [WW-1:0]     map_new;
  logic [SzW:0]      size_dbl;

  assign free_tag_ext = SzW'(req_tag);
  assign free_word    = MapAW'(free_tag_ext >> 6);
  assign free_legal   = (req_tag != '0) && (free_tag_ext < active_size);
  assign map_hit      = SzW'({word_idx, lfta_pkg::low_bit(map_rdata)});
  assign size_dbl     = {active_size, 1'b0};

  // Decide the allocation once the bitmap word is in hand.
  always_comb begin
    grant_tag  = '0;
    grant_ok   = 1'b0;
    grant_grew = 1'b0;
    if (found && map_rdata != '0 && map_hit < active_size) begin
      grant_tag = map_hit;
      grant_ok  = 1'b1;
    end else if (size_dbl <= (SzW+1)'(MAX_TAGS)) begin
      grant_tag  = active_size;
      grant_ok   = 1'b1;
      grant_grew = 1'b1;
    end
  end
  assign grant_word = MapAW'(grant_tag >> 6);

  // Bitmap word after the update; on growth the read word is not the target,
  // but bits of a never-used word are all ones, so rebuild it from scratch.
  always_comb begin
    map_new = map_rdata;
    if (req_kind == lfta_pkg::KindFree) begin
      map_new[free_tag_ext[5:0]] = 1'b1;
    end else if (grant_grew) begin
      map_new = '1;
      map_new[grant_tag[5:0]] = 1'b0;
    end else begin
      map_new[grant_tag[5:0]] = 1'b0;
    end
  end

  logic [WW-1:0] sum_keep;
  logic [MapAW-1:0] upd_word;
  assign upd_word = (req_kind == lfta_pkg::KindFree) ? free_word : grant_word;

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = SumAW'(upd_word >> 6);
    sum_wdata = sum_rdata;
    map_we    = 1'b0;
    map_waddr = upd_word;
    map_wdata = map_new;
    sum_raddr = scan_idx;
    map_raddr = word_idx;
    sum_keep  = sum_rdata;
    sum_keep[upd_word[5:0]] = (map_new != '0);
    unique case (state)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt[MapAW-1:0];
        map_wdata = (clr_cnt == '0) ? {{(WW-1){1'b1}}, 1'b0} : '1;
        sum_we    = (clr_cnt < (MapAW+1)'(SumWords));
        sum_waddr = SumAW'(clr_cnt);
        sum_wdata = '1;
      end
      ST_OUT: begin
        // Fetch the summary word of the group about to change.
        sum_raddr = SumAW'(upd_word >> 6);
      end
      ST_WRITE: begin
        if (req_kind == lfta_pkg::KindFree) begin
          map_we = free_legal;
          sum_we = free_legal;
        end else begin
          map_we = grant_ok;
          sum_we = grant_ok;
        end
        sum_wdata = sum_keep;
      end
      default: begin
      end
    endcase
  end

  // Take a new request whenever idle; a held result stops it in ST_OUT.
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      active_size <= SzW'(START_SIZE);
      avail_cnt   <= CntW'(MAX_TAGS - 1);
      out_valid   <= 1'b0;
      scan_idx    <= '0;
      found       <= 1'b0;
      word_idx    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (MapAW+1)'(MapWords - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_kind <= kind;
            req_tag  <= tag;
            scan_idx <= '0;
            found    <= 1'b0;
            word_idx <= MapAW'(SzW'(tag) >> 6);
            state    <= (kind == lfta_pkg::KindFree) ? ST_MREAD : ST_SREAD;
          end
        end
        ST_SREAD: begin
          state <= ST_SEL;
        end
        ST_SEL: begin
          // Scan summary words in order; advance to the next on an empty one.
          if (sum_rdata != '0) begin
            found    <= 1'b1;
            word_idx <= MapAW'({scan_idx, lfta_pkg::low_bit(sum_rdata)});
            state    <= ST_MREAD;
          end else if (scan_idx == SumAW'(SumWords - 1)) begin
            state <= ST_MREAD;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= ST_SREAD;
          end
        end
        ST_MREAD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Bitmap word valid now; hold while the previous result still waits.
          if (!out_valid || out_ready) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (req_kind == lfta_pkg::KindFree) begin
            granted_tag <= '0;
            grew        <= 1'b0;
            ok          <= free_legal;
            if (free_legal && avail_cnt != CntW'(MAX_TAGS - 1)) begin
              avail_cnt <= avail_cnt + 1'b1;
            end
            pool_size <= lfta_pkg::SizeW'(active_size);
            available <= TW'(avail_cnt + ((free_legal &&
                         avail_cnt != CntW'(MAX_TAGS - 1)) ? 1'b1 : 1'b0));
          end else begin
            granted_tag <= TW'(grant_tag);
            ok          <= grant_ok;
            grew        <= grant_grew;
            if (grant_grew) begin
              active_size <= SzW'(size_dbl);
            end
            pool_size <= lfta_pkg::SizeW'(grant_grew ? SzW'(size_dbl) : active_size);
            if (grant_ok && avail_cnt != '0) begin
              avail_cnt <= avail_cnt - 1'b1;
            end
            available <= TW'(avail_cnt - ((grant_ok && avail_cnt != '0) ? 1'b1 : 1'b0));
          end
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");
  a_result_after_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> out_valid)
    else $error("result not presented after write-back");
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    active_size <= SzW'(MAX_TAGS))
    else $error("pool size beyond maximum");
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ok && !grew && granted_tag != '0) |->
      lfta_pkg::SizeW'(granted_tag) < pool_size)
    else $error("granted tag outside pool");
`endif

endmodule
